FILE: rtl/ant_colony_depot_selector_defines.svh
// Assertion macros shared by the depot selector.
`ifndef ANT_COLONY_DEPOT_SELECTOR_DEFINES_SVH
`define ANT_COLONY_DEPOT_SELECTOR_DEFINES_SVH
`define ACDS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ACDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: rtl/acds_pkg.sv
`timescale 1ns / 1ps
package acds_pkg;
  localparam int unsigned MaxDepotsDef = 16;
  localparam int unsigned FracBitsDef  = 16;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 32;
  localparam logic [15:0] GreedyLimit  = 16'd32768;
  localparam logic [10:0] UseMax       = 11'd2047;

  typedef enum logic [CfgIdxW-1:0] {
    REG_NUM_DEPOTS = 3'd0, REG_NUM_ANTS = 3'd1, REG_NUM_ITERS = 3'd2,
    REG_INIT_LEVEL = 3'd3, REG_CLIENTS = 3'd4, REG_CAPACITY = 3'd5
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_SUM, ST_MUL, ST_SCAN, ST_COMMIT, ST_OUT, ST_EVAP_MUL,
    ST_EVAP_DIV, ST_DEP_MUL, ST_DEP_WR, ST_DEPDIV
  } state_e;

  typedef struct packed {
    logic [1:0]  extra_open;
    logic [15:0] explore_draw;
    logic [15:0] wheel_draw;
  } in_item_t;

  typedef struct packed {
    logic [3:0] depot;
    logic       end_of_ant;
    logic       end_of_iteration;
    logic       is_final;
    logic       last;
  } out_item_t;
endpackage

FILE: rtl/ant_colony_depot_selector.sv
`timescale 1ns / 1ps
// Steps: an ant's first pick divides clients by capacity for its open count; a greedy pick
// scans the depots once and a wheel pick sums them, scales the draw and scans again.
// Closing an iteration updates the table for every depot before the next request is taken.
// Only one request is in flight at a time; a final selection of K depots answers one request.
// Reset is asynchronous and active low; it restores config, control state and tables.
`include "ant_colony_depot_selector_defines.svh"
module ant_colony_depot_selector #(
  parameter int unsigned MAX_DEPOTS = acds_pkg::MaxDepotsDef,
  parameter int unsigned FRAC_BITS  = acds_pkg::FracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [acds_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [acds_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  acds_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output acds_pkg::out_item_t           out_data_o
);
  import acds_pkg::*;

  localparam int unsigned IW = $clog2(MAX_DEPOTS);
  localparam int unsigned CW = $clog2(MAX_DEPOTS + 1);
  localparam int unsigned SW = 32 + CW;
  localparam logic [31:0] InitRst = 32'(64'd1 << FRAC_BITS);

  logic [4:0]  nd_cfg_q;
  logic [9:0]  n_ants_q;
  logic [11:0] n_iter_q;
  logic [31:0] init_q;
  logic [15:0] clients_q, cap_q;

  logic [31:0] pher_q [MAX_DEPOTS];
  logic [10:0] use_q  [MAX_DEPOTS];
  logic [MAX_DEPOTS-1:0] mask_q, mask_d;
  logic [4:0]  picks_q, picks_d;
  logic        greedy_q, greedy_d;
  logic [9:0]  ant_q, ant_d;
  logic [11:0] iter_q, iter_d;

  state_e st_q, st_d;
  in_item_t req_q, req_d;
  logic final_q, final_d;
  logic [4:0] cnt_q, cnt_d;
  logic [IW:0] idx_q, idx_d;
  logic [IW-1:0] best_q, best_d;
  logic found_q, found_d;
  logic [SW-1:0] acc_q, acc_d;
  logic [SW+15:0] thr_q, thr_d;
  logic [31:0] rem_q, rem_d;
  logic [15:0] quo_q, quo_d;
  logic [4:0] step_q, step_d;
  logic [63:0] prod_q, prod_d;
  logic [31:0] dep_q, dep_d;
  out_item_t out_q, out_d;
  logic ov_q, ov_d;
  logic wr_en, use_inc, evap_wr, reload;
  logic [31:0] evap_val;

  logic [CW-1:0] nd_act;
  always_comb begin
    if (nd_cfg_q == 5'd0) nd_act = CW'(1);
    else if (32'(nd_cfg_q) > MAX_DEPOTS) nd_act = CW'(MAX_DEPOTS);
    else nd_act = CW'(nd_cfg_q);
  end

  function automatic logic anyelig();
    logic r;
    r = 1'b0;
    for (int i = 0; i < MAX_DEPOTS; i++)
      if (32'(i) < 32'(nd_act) && !mask_q[i]) r = 1'b1;
    return r;
  endfunction

  logic [IW-1:0] ci;
  logic in_rng, elig;
  logic [31:0] pv;
  assign ci     = idx_q[IW-1:0];
  assign in_rng = 32'(idx_q) < 32'(nd_act);
  assign pv     = pher_q[ci];
  assign elig   = in_rng && !mask_q[ci];

  // Division by ten is a multiplication by the rounded-up reciprocal 2^35/10.
  logic [31:0] recip_src;
  logic [63:0] recip_prod;
  logic [31:0] tenth, ninth;
  assign recip_src  = (st_q == ST_DEPDIV) ? init_q : pv;
  assign recip_prod = 64'(recip_src) * 64'h0000_0000_CCCC_CCCD;
  assign tenth      = 32'(prod_q[63:35]);
  assign ninth      = pv - tenth -
                      32'((pv - ((tenth << 3) + (tenth << 1))) != 32'd0);

  logic [17:0] open_sum;
  logic [4:0]  open_cnt;
  logic [15:0] cap_act;
  logic [32:0] sub;
  assign cap_act  = (cap_q == 16'd0) ? 16'd1 : cap_q;
  assign open_sum = 18'(quo_q) + 18'((req_q.extra_open == 2'd0) ? 2'd1 : req_q.extra_open);
  assign open_cnt = (open_sum > 18'(nd_act)) ? 5'(nd_act) : open_sum[4:0];
  assign sub      = {rem_q[31:0], quo_q[15]} - {17'd0, cap_act};

  always_comb begin
    st_d = st_q; req_d = req_q; final_d = final_q; cnt_d = cnt_q; idx_d = idx_q;
    best_d = best_q; found_d = found_q; acc_d = acc_q; thr_d = thr_q; rem_d = rem_q;
    quo_d = quo_q; step_d = step_q; prod_d = prod_q; dep_d = dep_q; out_d = out_q;
    ov_d = ov_q; mask_d = mask_q; picks_d = picks_q; greedy_d = greedy_q;
    ant_d = ant_q; iter_d = iter_q; use_inc = 1'b0; evap_wr = 1'b0;
    reload = 1'b0; evap_val = 32'd0;
    in_ready_o = 1'b0;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_d = in_data_i;
          final_d = (picks_q == 5'd0) && (iter_q >= n_iter_q);
          if (picks_q == 5'd0) begin
            rem_d = 32'd0; quo_d = clients_q; step_d = 5'd0; st_d = ST_DIV;
          end else begin
            idx_d = '0; acc_d = '0; found_d = 1'b0; st_d = ST_SUM;
          end
        end
      end
      ST_DIV: begin
        if (!sub[32]) begin
          rem_d = sub[31:0]; quo_d = {quo_q[14:0], 1'b1};
        end else begin
          rem_d = {rem_q[30:0], quo_q[15]}; quo_d = {quo_q[14:0], 1'b0};
        end
        step_d = step_q + 5'd1;
        if (step_q == 5'd15) st_d = ST_OUT;
      end
      ST_OUT: begin
        // Open count is ready; start the ant or the final run.
        cnt_d = open_cnt;
        if (final_q) begin
          mask_d = '0; greedy_d = 1'b1;
        end else begin
          picks_d = open_cnt; greedy_d = req_q.explore_draw <= GreedyLimit; mask_d = '0;
        end
        idx_d = '0; acc_d = '0; found_d = 1'b0; st_d = ST_SUM;
      end
      ST_SUM: begin
        if (greedy_q) begin
          if (elig && (!found_q || pv >= pher_q[best_q])) begin
            best_d = ci; found_d = 1'b1;
          end
        end else if (elig) begin
          acc_d = acc_q + SW'(pv);
        end
        idx_d = idx_q + 1'b1;
        if (32'(idx_q) == MAX_DEPOTS - 1) st_d = greedy_q ? ST_COMMIT : ST_MUL;
      end
      ST_MUL: begin
        thr_d = (SW+16)'(acc_q) * (SW+16)'(req_q.wheel_draw);
        idx_d = '0; acc_d = '0; found_d = 1'b0; st_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (elig && !found_q) begin
          acc_d = acc_q + SW'(pv); best_d = ci;
          if ((SW+16)'(acc_q + SW'(pv)) >= (thr_q >> 16)) found_d = 1'b1;
        end
        idx_d = idx_q + 1'b1;
        if (32'(idx_q) == MAX_DEPOTS - 1) st_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (!found_q && greedy_q) best_d = '0;
        if (!greedy_q && !found_q && !anyelig()) best_d = '0;
        if (!ov_q || out_ready_i) begin
          mask_d = mask_q | (MAX_DEPOTS'(1) << best_d);
          out_d.depot = 4'(best_d);
          out_d.is_final = final_q;
          ov_d = 1'b1;
          if (final_q) begin
            cnt_d = cnt_q - 5'd1;
            out_d.end_of_ant = 1'b0; out_d.end_of_iteration = 1'b0;
            out_d.last = (cnt_q == 5'd1);
            if (cnt_q == 5'd1) begin
              reload = 1'b1; iter_d = '0; st_d = ST_IDLE;
            end else begin
              idx_d = '0; found_d = 1'b0; st_d = ST_SUM;
            end
          end else begin
            use_inc = 1'b1;
            picks_d = picks_q - 5'd1;
            out_d.last = 1'b1;
            out_d.end_of_ant = (picks_q == 5'd1);
            out_d.end_of_iteration = 1'b0;
            st_d = ST_IDLE;
            if (picks_q == 5'd1) begin
              ant_d = ant_q + 10'd1;
              if (ant_q + 10'd1 >= n_ants_q) begin
                out_d.end_of_iteration = 1'b1;
                ant_d = '0; iter_d = iter_q + 12'd1;
                st_d = ST_DEPDIV;
              end
            end
          end
        end
      end
      ST_DEPDIV: begin
        dep_d = 32'(recip_prod[63:35]); idx_d = '0; st_d = ST_EVAP_MUL;
      end
      ST_EVAP_MUL: begin
        prod_d = recip_prod;
        st_d = ST_EVAP_DIV;
      end
      ST_EVAP_DIV: begin
        // Nine tenths rounded down is the level minus its tenth rounded up.
        prod_d = 64'(ninth);
        st_d = ST_DEP_MUL;
      end
      ST_DEP_MUL: begin
        thr_d = (SW+16)'(64'(use_q[ci]) * 64'(dep_q));
        st_d = ST_DEP_WR;
      end
      ST_DEP_WR: begin
        evap_wr = 1'b1;
        if ((64'(prod_q) + 64'(thr_q)) > 64'hFFFF_FFFF) evap_val = 32'hFFFF_FFFF;
        else evap_val = 32'(64'(prod_q) + 64'(thr_q));
        idx_d = idx_q + 1'b1;
        st_d = (32'(idx_q) == MAX_DEPOTS - 1) ? ST_IDLE : ST_EVAP_MUL;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  assign wr_en = cfg_we_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nd_cfg_q <= 5'd16; n_ants_q <= 10'd8; n_iter_q <= 12'd10; init_q <= InitRst;
      clients_q <= '0; cap_q <= 16'd1;
      for (int i = 0; i < MAX_DEPOTS; i++) begin
        pher_q[i] <= InitRst; use_q[i] <= '0;
      end
      mask_q <= '0; picks_q <= '0; greedy_q <= 1'b0; ant_q <= '0; iter_q <= '0;
      st_q <= ST_IDLE; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; ov_q <= ov_d; mask_q <= mask_d; picks_q <= picks_d;
      greedy_q <= greedy_d; ant_q <= ant_d; iter_q <= iter_d;
      if (use_inc && use_q[best_d] < UseMax) use_q[best_d] <= use_q[best_d] + 11'd1;
      if (evap_wr) begin
        pher_q[ci] <= evap_val; use_q[ci] <= '0;
      end
      if (reload) for (int i = 0; i < MAX_DEPOTS; i++) pher_q[i] <= init_q;
      if (wr_en) begin
        case (cfg_idx_i)
          REG_NUM_DEPOTS: nd_cfg_q <= cfg_data_i[4:0];
          REG_NUM_ANTS:   n_ants_q <= cfg_data_i[9:0];
          REG_NUM_ITERS:  n_iter_q <= cfg_data_i[11:0];
          REG_INIT_LEVEL: begin
            init_q <= cfg_data_i;
            for (int i = 0; i < MAX_DEPOTS; i++) pher_q[i] <= cfg_data_i;
          end
          REG_CLIENTS:    clients_q <= cfg_data_i[15:0];
          REG_CAPACITY:   cap_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d; final_q <= final_d; cnt_q <= cnt_d; idx_q <= idx_d;
    best_q <= best_d; found_q <= found_d; acc_q <= acc_d; thr_q <= thr_d;
    rem_q <= rem_d; quo_q <= quo_d; step_q <= step_d; prod_q <= prod_d;
    dep_q <= dep_d; out_q <= out_d;
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

  `ACDS_ASSERT_IMPL(a_ready_idle, clk_i, rst_ni, in_ready_o, st_q == ST_IDLE)
  `ACDS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `ACDS_ASSERT_IMPL(a_final_flags, clk_i, rst_ni, out_valid_o && out_data_o.is_final,
                    !out_data_o.end_of_ant && !out_data_o.end_of_iteration)
endmodule
